>>> hdl/tkm_pkg.sv
`timescale 1ns / 1ps

package tkm_pkg;

   // field widths of one item and one result
   localparam int unsigned LANE_FIELD_W = 2;
   localparam int unsigned TIME_W       = 63;
   localparam int unsigned PAY_W        = 32;
   localparam int unsigned STATUS_W     = 2;
   localparam int unsigned CSR_W        = 3;

   // stream data bus: lane, time, payload, padded up to whole bytes
   localparam int unsigned TDATA_W = 104;
   localparam int unsigned PAD_W   = TDATA_W - LANE_FIELD_W - TIME_W - PAY_W;

   // one queue entry holds time above payload
   localparam int unsigned ENTRY_W = TIME_W + PAY_W;

   localparam logic [CSR_W-1:0] LANES_IN_USE_RST = 3'd4;

   // item kinds
   localparam logic KIND_RECORD = 1'b0;
   localparam logic KIND_END    = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_RECORD = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DROP   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_DONE   = 2'd2;

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic [PAY_W-1:0]        pay;
      logic [TIME_W-1:0]       tstamp;
      logic [LANE_FIELD_W-1:0] lane;
   } tkm_result_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_UPDATE,
      S_SCAN,
      S_DECIDE,
      S_PUSH,
      S_FLUSH
   } tkm_state_type;

endpackage

>>> hdl/tkm_ram.sv
`timescale 1ns / 1ps

module tkm_ram #(
   parameter int unsigned WIDTH = 95,
   parameter int unsigned DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/timestamp_kway_merge_core.sv
`timescale 1ns / 1ps
// order: an item is taken in the idle state and checked in the next; each merge round then
//   scans the lanes in use through the queue memory, then decides and pushes a result
// items: a new item is taken only back in the idle state, after the last one is fully handled;
//   the lanes share the single time comparator and the one read port of the queue memory
// reset: synchronous, active high; queues empty, no lane ended, lanes_in_use = 4

module timestamp_kway_merge_core
   import tkm_pkg::*;
#(
   parameter int unsigned LANES       = 4,
   parameter int unsigned QUEUE_DEPTH = 8
) (
   input  logic               clock,
   input  logic               reset,

   // input records and end marks
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [TDATA_W-1:0] req_tdata,   // lane[1:0], time_stamp[64:2], payload[96:65], zeros
   input  logic               req_tuser,   // kind

   // merged results
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [TDATA_W-1:0] rsp_tdata,   // out_lane[1:0], out_time[64:2], out_payload[96:65], zeros
   output logic [STATUS_W-1:0] rsp_tuser,  // status
   output logic               rsp_tlast,   // last result caused by the input item

   // lanes_in_use register
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CSR_W-1:0]   csr_data
);

   localparam int unsigned LANE_W  = $clog2(LANES);
   localparam int unsigned CNT_RAW = $clog2(LANES + 1);
   // lane counter wide enough for the register value and the lane count
   localparam int unsigned N_W     = (CNT_RAW > CSR_W) ? CNT_RAW : CSR_W;
   localparam int unsigned SLOT_W  = $clog2(QUEUE_DEPTH);
   localparam int unsigned FILL_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned DEPTH   = LANES * QUEUE_DEPTH;
   localparam int unsigned ADDR_W  = $clog2(DEPTH);

   // ---------------------------------------------------------------------------------------
   // state
   // ---------------------------------------------------------------------------------------
   tkm_state_type state_ff, state_in;

   logic [CSR_W-1:0]        lanes_in_use_ff, lanes_in_use_in;
   logic [N_W-1:0]          n_ff, n_in;             // clamped lane count for this item

   // captured item
   logic                    item_kind_ff, item_kind_in;
   logic [LANE_FIELD_W-1:0] item_lane_ff, item_lane_in;
   logic [TIME_W-1:0]       item_time_ff, item_time_in;
   logic [PAY_W-1:0]        item_pay_ff, item_pay_in;

   // per-lane queue control
   logic [SLOT_W-1:0]       head_ff [LANES];
   logic [SLOT_W-1:0]       head_in [LANES];
   logic [FILL_W-1:0]       fill_ff [LANES];
   logic [FILL_W-1:0]       fill_in [LANES];
   logic [LANES-1:0]        ended_ff, ended_in;
   logic                    finished_ff, finished_in;

   // scan of the lane heads
   logic [N_W-1:0]          scan_idx_ff, scan_idx_in;
   logic                    rd_pend_ff, rd_pend_in;  // memory read in flight
   logic [LANE_W-1:0]       rd_lane_ff, rd_lane_in;
   logic                    any_ff, any_in;          // some lane holds a record
   logic                    all_ready_ff, all_ready_in;
   logic [LANE_W-1:0]       best_lane_ff, best_lane_in;
   logic [TIME_W-1:0]       best_time_ff, best_time_in;
   logic [PAY_W-1:0]        best_pay_ff, best_pay_in;

   // result path: new result, one held back to learn its last flag, output register
   tkm_result_type          res_ff, res_in;
   logic                    flush_after_ff, flush_after_in;
   tkm_result_type          pend_ff, pend_in;
   logic                    pend_valid_ff, pend_valid_in;
   tkm_result_type          rsp_ff, rsp_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // ---------------------------------------------------------------------------------------
   // shared lane select: one read of the lane control per cycle
   // ---------------------------------------------------------------------------------------
   logic [N_W-1:0]          item_lane_ext;
   logic [N_W-1:0]          best_lane_ext;
   logic [LANE_W-1:0]       lane_sel;
   logic [SLOT_W-1:0]       sel_head;
   logic [FILL_W-1:0]       sel_fill;
   logic                    sel_ended;
   logic                    lane_ok;
   logic                    idx_lt_n;
   logic                    out_free;
   logic [N_W-1:0]          csr_n;

   assign item_lane_ext = N_W'(item_lane_ff);
   assign best_lane_ext = N_W'(best_lane_ff);
   assign lane_ok       = item_lane_ext < n_ff;
   assign idx_lt_n      = scan_idx_ff < n_ff;
   assign out_free      = !rsp_valid_ff || rsp_tready;
   assign csr_n         = N_W'(lanes_in_use_ff);

   always_comb begin
      unique case (state_ff)
         S_UPDATE: lane_sel = item_lane_ext[LANE_W-1:0];
         S_SCAN:   lane_sel = scan_idx_ff[LANE_W-1:0];
         default:  lane_sel = best_lane_ff;
      endcase
   end

   assign sel_head  = head_ff[lane_sel];
   assign sel_fill  = fill_ff[lane_sel];
   assign sel_ended = ended_ff[lane_sel];

   // ---------------------------------------------------------------------------------------
   // queue memory: {time, payload} per entry, lane-major
   // ---------------------------------------------------------------------------------------
   logic                ram_wr_en;
   logic [ADDR_W-1:0]   ram_wr_addr;
   logic                ram_rd_en;
   logic [ADDR_W-1:0]   ram_rd_addr;
   logic [ENTRY_W-1:0]  ram_rd_data;
   logic [SLOT_W:0]     slot_sum;
   logic [SLOT_W-1:0]   wr_slot;
   logic [ADDR_W-1:0]   lane_base;
   logic [TIME_W-1:0]   rd_time;
   logic [PAY_W-1:0]    rd_pay;

   // tail slot wraps once at most: head and fill both stay below the depth here
   assign slot_sum    = (SLOT_W + 1)'(sel_head) + (SLOT_W + 1)'(sel_fill);
   assign wr_slot     = (slot_sum >= (SLOT_W + 1)'(QUEUE_DEPTH))
                        ? SLOT_W'(slot_sum - (SLOT_W + 1)'(QUEUE_DEPTH))
                        : SLOT_W'(slot_sum);
   assign lane_base   = ADDR_W'(lane_sel) * ADDR_W'(QUEUE_DEPTH);
   assign ram_wr_addr = lane_base + ADDR_W'(wr_slot);
   assign ram_rd_addr = lane_base + ADDR_W'(sel_head);
   assign rd_time     = ram_rd_data[ENTRY_W-1:PAY_W];
   assign rd_pay      = ram_rd_data[PAY_W-1:0];

   tkm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data ({item_time_ff, item_pay_ff}),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------------------------------
   // sequencer: next state
   // ---------------------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            priority if (finished_ff || !lane_ok) begin
               state_in = S_IDLE;              // ignored item, no result
            end else if (item_kind_ff == KIND_END) begin
               state_in = S_SCAN;
            end else if (sel_ended || sel_fill == FILL_W'(QUEUE_DEPTH)) begin
               state_in = S_PUSH;              // drop report first
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (!idx_lt_n) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (!all_ready_ff) begin
               state_in = S_FLUSH;
            end else begin
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            if (!pend_valid_ff || out_free) begin
               state_in = flush_after_ff ? S_FLUSH : S_SCAN;
            end
         end
         S_FLUSH: begin
            if (!pend_valid_ff || out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------------------------
   // sequencer: datapath and outputs
   // ---------------------------------------------------------------------------------------
   logic scan_start;

   assign scan_start = (state_in == S_SCAN) && (state_ff != S_SCAN);

   always_comb begin
      lanes_in_use_in = lanes_in_use_ff;
      n_in            = n_ff;
      item_kind_in    = item_kind_ff;
      item_lane_in    = item_lane_ff;
      item_time_in    = item_time_ff;
      item_pay_in     = item_pay_ff;
      head_in         = head_ff;
      fill_in         = fill_ff;
      ended_in        = ended_ff;
      finished_in     = finished_ff;
      scan_idx_in     = scan_idx_ff;
      rd_pend_in      = rd_pend_ff;
      rd_lane_in      = rd_lane_ff;
      any_in          = any_ff;
      all_ready_in    = all_ready_ff;
      best_lane_in    = best_lane_ff;
      best_time_in    = best_time_ff;
      best_pay_in     = best_pay_ff;
      res_in          = res_ff;
      flush_after_in  = flush_after_ff;
      pend_in         = pend_ff;
      pend_valid_in   = pend_valid_ff;
      rsp_in          = rsp_ff;
      rsp_last_in     = rsp_last_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      ram_wr_en       = 1'b0;
      ram_rd_en       = 1'b0;
      req_tready      = 1'b0;

      // the user must write the register only while idle; the block itself does not enforce it
      if (csr_valid) begin
         lanes_in_use_in = csr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            req_tready   = 1'b1;
            item_kind_in = req_tuser;
            item_lane_in = req_tdata[LANE_FIELD_W-1:0];
            item_time_in = req_tdata[LANE_FIELD_W +: TIME_W];
            item_pay_in  = req_tdata[LANE_FIELD_W + TIME_W +: PAY_W];
            // clamp the lane count to 1 .. LANES
            priority if (csr_n == '0) begin
               n_in = N_W'(1);
            end else if (csr_n > N_W'(LANES)) begin
               n_in = N_W'(LANES);
            end else begin
               n_in = csr_n;
            end
         end
         S_UPDATE: begin
            flush_after_in = 1'b0;
            if (!finished_ff && lane_ok) begin
               priority if (item_kind_ff == KIND_END) begin
                  ended_in[lane_sel] = 1'b1;
               end else if (sel_ended || sel_fill == FILL_W'(QUEUE_DEPTH)) begin
                  res_in.lane   = item_lane_ff;
                  res_in.tstamp = item_time_ff;
                  res_in.pay    = item_pay_ff;
                  res_in.status = ST_DROP;
               end else begin
                  ram_wr_en         = 1'b1;
                  fill_in[lane_sel] = sel_fill + FILL_W'(1);
               end
            end
         end
         S_SCAN: begin
            // compare the head read last cycle with the best so far
            if (rd_pend_ff && (!any_ff || rd_time < best_time_ff)) begin
               any_in       = 1'b1;
               best_lane_in = rd_lane_ff;
               best_time_in = rd_time;
               best_pay_in  = rd_pay;
            end
            rd_pend_in = 1'b0;
            if (idx_lt_n) begin
               scan_idx_in = scan_idx_ff + N_W'(1);
               if (sel_fill != '0) begin
                  ram_rd_en  = 1'b1;
                  rd_pend_in = 1'b1;
                  rd_lane_in = lane_sel;
               end else if (!sel_ended) begin
                  all_ready_in = 1'b0;       // open lane still waits for a record
               end
            end
         end
         S_DECIDE: begin
            if (all_ready_ff) begin
               if (!any_ff) begin
                  // every lane in use ended and drained
                  res_in.lane    = '0;
                  res_in.tstamp  = '0;
                  res_in.pay     = '0;
                  res_in.status  = ST_DONE;
                  finished_in    = 1'b1;
                  flush_after_in = 1'b1;
               end else begin
                  res_in.lane        = best_lane_ext[LANE_FIELD_W-1:0];
                  res_in.tstamp      = best_time_ff;
                  res_in.pay         = best_pay_ff;
                  res_in.status      = ST_RECORD;
                  flush_after_in     = 1'b0;
                  head_in[lane_sel]  = (sel_head == SLOT_W'(QUEUE_DEPTH - 1))
                                       ? '0 : sel_head + SLOT_W'(1);
                  fill_in[lane_sel]  = sel_fill - FILL_W'(1);
               end
            end
         end
         S_PUSH: begin
            // a newer result exists, so the held one is not the last
            if (!pend_valid_ff) begin
               pend_in       = res_ff;
               pend_valid_in = 1'b1;
            end else if (out_free) begin
               rsp_in       = pend_ff;
               rsp_last_in  = 1'b0;
               rsp_valid_in = 1'b1;
               pend_in      = res_ff;
            end
         end
         S_FLUSH: begin
            if (pend_valid_ff && out_free) begin
               rsp_in        = pend_ff;
               rsp_last_in   = 1'b1;
               rsp_valid_in  = 1'b1;
               pend_valid_in = 1'b0;
            end
         end
         default: begin
         end
      endcase

      if (scan_start) begin
         scan_idx_in  = '0;
         rd_pend_in   = 1'b0;
         any_in       = 1'b0;
         all_ready_in = 1'b1;
      end
   end

   // ---------------------------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         lanes_in_use_ff <= LANES_IN_USE_RST;
         for (int i = 0; i < LANES; i++) begin
            head_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
         ended_ff        <= '0;
         finished_ff     <= 1'b0;
         rd_pend_ff      <= 1'b0;
         any_ff          <= 1'b0;
         all_ready_ff    <= 1'b0;
         flush_after_ff  <= 1'b0;
         pend_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         lanes_in_use_ff <= lanes_in_use_in;
         head_ff         <= head_in;
         fill_ff         <= fill_in;
         ended_ff        <= ended_in;
         finished_ff     <= finished_in;
         rd_pend_ff      <= rd_pend_in;
         any_ff          <= any_in;
         all_ready_ff    <= all_ready_in;
         flush_after_ff  <= flush_after_in;
         pend_valid_ff   <= pend_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      item_kind_ff <= item_kind_in;
      item_lane_ff <= item_lane_in;
      item_time_ff <= item_time_in;
      item_pay_ff  <= item_pay_in;
      scan_idx_ff  <= scan_idx_in;
      rd_lane_ff   <= rd_lane_in;
      best_lane_ff <= best_lane_in;
      best_time_ff <= best_time_in;
      best_pay_ff  <= best_pay_in;
      res_ff       <= res_in;
      pend_ff      <= pend_in;
      rsp_ff       <= rsp_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // ---------------------------------------------------------------------------------------
   // outputs
   // ---------------------------------------------------------------------------------------
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_ff.pay, rsp_ff.tstamp, rsp_ff.lane};
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tlast  = rsp_last_ff;

endmodule
